[sv/ucmft_pkg.sv]
// shared types and constants for the command frame receiver and mac filter table
// no dependencies; used by ucmft_cell and the top level
package ucmft_pkg;

   localparam int BYTE_W = 8;
   localparam int MAC_BYTES = 6;
   localparam int MAC_W = BYTE_W * MAC_BYTES;
   localparam int FRAME_LEN_W = 7;
   localparam int HEAD_DEPTH = 10;
   localparam int HEAD_IDX_W = 4;
   localparam int MAC_OFFSET = 4;
   localparam int TABLE_ENTRIES_DEF = 8;

   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 7'd20;
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MIN = 7'd10;

   localparam logic [BYTE_W-1:0] HDR_FIRST = 8'ha5;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h5a;
   localparam logic [BYTE_W-1:0] ACK_OK = 8'h96;
   localparam logic [BYTE_W-1:0] ACK_FAIL = 8'h67;

   localparam logic [BYTE_W-1:0] OP_ADD = 8'h01;
   localparam logic [BYTE_W-1:0] OP_DELETE = 8'h02;
   localparam logic [BYTE_W-1:0] OP_DUMP = 8'h03;
   localparam logic [BYTE_W-1:0] OP_SCAN = 8'h04;
   localparam logic [BYTE_W-1:0] OP_RESET = 8'h05;

   // per-cell control: load the frame address or take the neighbor's entry
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

[sv/ucmft_cell.sv]
// one table cell: holds one mac entry, compares it against the frame address
// and loads it or shifts in its upper neighbor's entry; depends on ucmft_pkg
module ucmft_cell import ucmft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic               live,
   input  logic [MAC_W-1:0]   key,
   input  logic [MAC_W-1:0]   nbr_entry,
   output logic [MAC_W-1:0]   entry,
   output logic               hit
);

   logic [MAC_W-1:0] entry_ff, entry_in;
   logic             hit_ff, hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = key;
      end else if (ctl.shift) begin
         entry_in = nbr_entry;
      end
      hit_in = live && (entry_ff == key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit = hit_ff;

endmodule

[sv/uart_command_mac_filter_table_top.sv]
// top level: frame gathering, command sequencer, output register and the cell row
// depends on ucmft_pkg and ucmft_cell
//
// Received bytes are taken while req_stall is low, as a frame is gathered. On the
// last byte of a frame the sequencer takes over; req_stall stays high until it is
// idle again: the cells compare in ST_MATCH, ST_EXEC decodes the command, and each
// result byte is loaded into the output register once free. A dump sends 6*n+2
// bytes for n entries (only the count byte for an empty table), then rotates the
// cell row around to its starting order. The table is a row of cells that compare
// in parallel and pass entries to their neighbor for delete and dump.
module uart_command_mac_filter_table_top import ucmft_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [FRAME_LEN_W-1:0]  csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [BYTE_W-1:0]       req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [BYTE_W-1:0]       rsp_tx_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_start_scan,
   output logic                    rsp_reset_request,
   output logic                    rsp_last
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_DUMP  = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_ROT   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [FRAME_LEN_W-1:0] frame_len_ff;
   logic [FRAME_LEN_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]      head_ff [HEAD_DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ent_ff, ent_in;
   logic [2:0]             pos_ff, pos_in;
   logic [BYTE_W-1:0]      sum_ff, sum_in;

   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      tx_byte_ff, tx_byte_in;
   logic                   byte_valid_ff, byte_valid_in;
   logic                   scan_ff, scan_in;
   logic                   rst_req_ff, rst_req_in;
   logic                   last_ff, last_in;
   logic                   out_load;

   logic                   accept;
   logic                   out_free;
   logic [FRAME_LEN_W-1:0] limit;
   logic [FRAME_LEN_W-1:0] idx_next;
   logic [MAC_W-1:0]       key;
   logic [MAC_W-1:0]       entry [TABLE_ENTRIES];
   logic                   hit [TABLE_ENTRIES];
   logic                   after [TABLE_ENTRIES];
   logic                   any_hit;
   logic                   do_add, do_delete, do_rotate;
   logic [MAC_W-1:0]       last_nbr;
   logic [BYTE_W-1:0]      dump_byte;
   cell_ctl_type           cell_ctl [TABLE_ENTRIES];

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign limit = (frame_len_ff < FRAME_LEN_MIN) ? FRAME_LEN_MIN : frame_len_ff;
   assign idx_next = idx_ff + FRAME_LEN_W'(1);

   always_comb begin
      for (int k = 0; k < MAC_BYTES; k++) begin
         key[k*BYTE_W +: BYTE_W] = head_ff[MAC_OFFSET + k];
      end
   end

   // first hit and everything above it moves down on a delete
   always_comb begin
      after[0] = hit[0];
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
         after[i] = after[i-1] || hit[i];
      end
   end
   assign any_hit = after[TABLE_ENTRIES-1];

   assign dump_byte = entry[0][pos_ff*BYTE_W +: BYTE_W];
   assign last_nbr = do_rotate ? entry[0] : '0;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      ent_in = ent_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      out_load = 1'b0;
      tx_byte_in = '0;
      byte_valid_in = 1'b1;
      scan_in = 1'b0;
      rst_req_in = 1'b0;
      last_in = 1'b1;
      do_add = 1'b0;
      do_delete = 1'b0;
      do_rotate = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (idx_ff == '0 && req_rx_byte != HDR_FIRST) begin
                  idx_in = '0;
               end else if (idx_next >= limit) begin
                  idx_in = '0;
                  state_in = ST_MATCH;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         ST_MATCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (head_ff[0] != HDR_FIRST || head_ff[1] != HDR_SECOND) begin
               if (out_free) begin
                  out_load = 1'b1;
                  tx_byte_in = ACK_FAIL;
                  state_in = ST_IDLE;
               end
            end else begin
               case (head_ff[2])
                  OP_ADD: begin
                     if (out_free) begin
                        out_load = 1'b1;
                        state_in = ST_IDLE;
                        if (count_ff >= CNT_W'(TABLE_ENTRIES)) begin
                           tx_byte_in = ACK_FAIL;
                        end else begin
                           tx_byte_in = ACK_OK;
                           if (!any_hit) begin
                              do_add = 1'b1;
                              count_in = count_ff + CNT_W'(1);
                           end
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (out_free) begin
                        out_load = 1'b1;
                        tx_byte_in = ACK_OK;
                        state_in = ST_IDLE;
                        if (any_hit) begin
                           do_delete = 1'b1;
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                  end
                  OP_DUMP: begin
                     if (out_free) begin
                        out_load = 1'b1;
                        tx_byte_in = BYTE_W'(count_ff);
                        if (count_ff == '0) begin
                           state_in = ST_IDLE;
                        end else begin
                           last_in = 1'b0;
                           sum_in = BYTE_W'(count_ff);
                           ent_in = '0;
                           pos_in = '0;
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  OP_SCAN: begin
                     if (out_free) begin
                        out_load = 1'b1;
                        tx_byte_in = ACK_OK;
                        scan_in = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  OP_RESET: begin
                     if (out_free) begin
                        out_load = 1'b1;
                        byte_valid_in = 1'b0;
                        rst_req_in = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               out_load = 1'b1;
               tx_byte_in = dump_byte;
               last_in = 1'b0;
               sum_in = sum_ff ^ dump_byte;
               if (pos_ff == 3'(MAC_BYTES - 1)) begin
                  pos_in = '0;
                  do_rotate = 1'b1;
                  ent_in = ent_ff + CNT_W'(1);
                  if (ent_ff + CNT_W'(1) == count_ff) begin
                     state_in = ST_SUM;
                  end
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
         end
         ST_SUM: begin
            if (out_free) begin
               out_load = 1'b1;
               tx_byte_in = sum_ff;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            // finish the full turn so the row is back in entry order
            if (ent_ff == CNT_W'(TABLE_ENTRIES)) begin
               state_in = ST_IDLE;
            end else begin
               do_rotate = 1'b1;
               ent_in = ent_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   generate
      for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         logic [MAC_W-1:0] nbr;
         if (i == TABLE_ENTRIES - 1) begin : g_top
            assign nbr = last_nbr;
         end else begin : g_mid
            assign nbr = entry[i+1];
         end
         assign cell_ctl[i].load = do_add && (count_ff == CNT_W'(i));
         assign cell_ctl[i].shift = do_rotate || (do_delete && after[i]);
         ucmft_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (cell_ctl[i]),
            .live      (CNT_W'(i) < count_ff),
            .key       (key),
            .nbr_entry (nbr),
            .entry     (entry[i]),
            .hit       (hit[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         frame_len_ff <= FRAME_LEN_RESET;
         idx_ff <= '0;
         count_ff <= '0;
         ent_ff <= '0;
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            frame_len_ff <= csr_wr_data;
         end
         idx_ff <= idx_in;
         count_ff <= count_in;
         ent_ff <= ent_in;
         pos_ff <= pos_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (accept && idx_ff < FRAME_LEN_W'(HEAD_DEPTH)) begin
         head_ff[idx_ff[HEAD_IDX_W-1:0]] <= req_rx_byte;
      end
      if (out_load) begin
         tx_byte_ff <= tx_byte_in;
         byte_valid_ff <= byte_valid_in;
         scan_ff <= scan_in;
         rst_req_ff <= rst_req_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tx_byte = tx_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_start_scan = scan_ff;
   assign rsp_reset_request = rst_req_ff;
   assign rsp_last = last_ff;

endmodule

[bench/testbench.sv]
// testbench for the command frame receiver and mac filter table
// depends on ucmft_pkg and uart_command_mac_filter_table_top; checks every reply byte
// against a behavioral model of the frame decoder and address table
`timescale 1ns / 1ps

module testbench;
   import ucmft_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int MAC_POOL = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 3 + 6 * TABLE_ENTRIES + TABLE_ENTRIES + 40;
   localparam int TIMEOUT_NS = 3_000_000;
   localparam int MAX_REPORTS = 20;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic byte_valid;
      logic start_scan;
      logic reset_request;
      logic last_flag;
   } reply_type;

   typedef enum int {
      KIND_ADD, KIND_DELETE, KIND_DUMP, KIND_SCAN, KIND_RESET,
      KIND_UNKNOWN, KIND_BAD_HEADER, KIND_NOISE
   } frame_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [FRAME_LEN_W-1:0] csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_tx_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_start_scan;
   logic                   rsp_reset_request;
   logic                   rsp_last;

   // decoder model state
   logic [FRAME_LEN_W-1:0] frame_len_cfg;
   logic [FRAME_LEN_W-1:0] gather_idx;
   logic [BYTE_W-1:0]      head_bytes [HEAD_DEPTH];
   logic [MAC_W-1:0]       mac_table [TABLE_ENTRIES];
   logic [3:0]             mac_count;

   reply_type         expected_replies [$];
   logic [BYTE_W-1:0] pending_bytes [$];
   logic [MAC_W-1:0]  mac_pool [MAC_POOL];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int bytes_accepted = 0;
   int frame_bytes_queued = 0;
   int replies_checked = 0;
   int mismatch_count = 0;
   int dump_count = 0;
   int add_refusals = 0;
   int peak_entries = 0;
   int random_start;
   logic      byte_taken;
   reply_type got, want;

   uart_command_mac_filter_table_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_start_scan    (rsp_start_scan),
      .rsp_reset_request (rsp_reset_request),
      .rsp_last          (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void push_reply(logic [BYTE_W-1:0] tx, logic bv, logic scan,
                                      logic rst, logic fin);
      expected_replies.push_back('{tx, bv, scan, rst, fin});
   endfunction

   function automatic string reply_text(reply_type r);
      return $sformatf("tx=%h valid=%b scan=%b rst=%b last=%b", r.tx_byte, r.byte_valid,
                       r.start_scan, r.reset_request, r.last_flag);
   endfunction

   // one received byte through the frame gatherer and command decoder
   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
      logic [FRAME_LEN_W-1:0] span;
      logic [MAC_W-1:0]       mac;
      logic [BYTE_W-1:0]      sum;
      int                     pos;
      span = (frame_len_cfg < FRAME_LEN_MIN) ? FRAME_LEN_MIN : frame_len_cfg;
      if (gather_idx < HEAD_DEPTH) head_bytes[gather_idx] = b;
      gather_idx = gather_idx + 7'd1;
      if (gather_idx == 7'd1 && head_bytes[0] != HDR_FIRST) begin
         gather_idx = '0;
         return;
      end
      if (gather_idx < span) return;
      gather_idx = '0;
      if (head_bytes[0] != HDR_FIRST || head_bytes[1] != HDR_SECOND) begin
         push_reply(ACK_FAIL, 1'b1, 1'b0, 1'b0, 1'b1);
         return;
      end
      for (int k = 0; k < MAC_BYTES; k++) mac[8*k +: 8] = head_bytes[MAC_OFFSET + k];
      pos = -1;
      for (int i = 0; i < mac_count; i++)
         if (pos < 0 && mac_table[i] == mac) pos = i;
      case (head_bytes[2])
         OP_ADD: begin
            if (mac_count >= TABLE_ENTRIES) begin
               add_refusals++;
               push_reply(ACK_FAIL, 1'b1, 1'b0, 1'b0, 1'b1);
            end else begin
               if (pos < 0) begin
                  mac_table[mac_count] = mac;
                  mac_count = mac_count + 4'd1;
                  if (int'(mac_count) > peak_entries) peak_entries = int'(mac_count);
               end
               push_reply(ACK_OK, 1'b1, 1'b0, 1'b0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (pos >= 0) begin
               for (int i = pos; i + 1 < mac_count; i++) mac_table[i] = mac_table[i + 1];
               mac_table[mac_count - 4'd1] = '0;
               mac_count = mac_count - 4'd1;
            end
            push_reply(ACK_OK, 1'b1, 1'b0, 1'b0, 1'b1);
         end
         OP_DUMP: begin
            dump_count++;
            if (mac_count == 0) begin
               push_reply(8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
            end else begin
               sum = {4'b0, mac_count};
               push_reply(sum, 1'b1, 1'b0, 1'b0, 1'b0);
               for (int i = 0; i < mac_count; i++)
                  for (int p = 0; p < MAC_BYTES; p++) begin
                     sum = sum ^ mac_table[i][8*p +: 8];
                     push_reply(mac_table[i][8*p +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                  end
               push_reply(sum, 1'b1, 1'b0, 1'b0, 1'b1);
            end
         end
         OP_SCAN:  push_reply(ACK_OK, 1'b1, 1'b1, 1'b0, 1'b1);
         OP_RESET: push_reply(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
         default: ;
      endcase
   endtask

   // driver: offers queued bytes, feeds accepted ones to the model
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         byte_taken = req_valid && !req_stall;
         if (byte_taken) begin
            decode_rx_byte(req_rx_byte);
            bytes_accepted++;
         end
         if (!req_valid || byte_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_rx_byte <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // monitor: every reply transfer against the oldest expected reply
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_tx_byte, rsp_byte_valid, rsp_start_scan, rsp_reset_request, rsp_last};
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected reply, expected none, got %s", $time,
                        reply_text(got));
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (got.tx_byte !== want.tx_byte || got.byte_valid !== want.byte_valid ||
                got.start_scan !== want.start_scan ||
                got.reset_request !== want.reset_request ||
                got.last_flag !== want.last_flag) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: reply mismatch, expected %s, got %s", $time,
                           reply_text(want), reply_text(got));
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_replies.size() != 0)
         @(posedge clock);
      // an unknown opcode leaves no reply but may still keep the sequencer busy
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_length(input logic [FRAME_LEN_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_len_cfg = v;
   endtask

   task automatic queue_frame(input logic [BYTE_W-1:0] op, input logic [BYTE_W-1:0] second,
                              input logic [MAC_W-1:0] mac);
      int span;
      span = int'((frame_len_cfg < FRAME_LEN_MIN) ? FRAME_LEN_MIN : frame_len_cfg);
      pending_bytes.push_back(HDR_FIRST);
      pending_bytes.push_back(second);
      pending_bytes.push_back(op);
      pending_bytes.push_back(8'($urandom_range(255)));
      for (int k = 0; k < MAC_BYTES; k++) pending_bytes.push_back(mac[8*k +: 8]);
      for (int k = HEAD_DEPTH; k < span; k++) pending_bytes.push_back(8'($urandom_range(255)));
      frame_bytes_queued += span;
   endtask

   task automatic queue_random_frame(input int add_pct);
      frame_kind_type    kind;
      logic [BYTE_W-1:0] op;
      logic [BYTE_W-1:0] second;
      int                roll;
      roll = $urandom_range(99);
      if (roll < add_pct) begin
         kind = KIND_ADD;
      end else begin
         roll = $urandom_range(99);
         if (roll < 30)      kind = KIND_DELETE;
         else if (roll < 50) kind = KIND_DUMP;
         else if (roll < 58) kind = KIND_SCAN;
         else if (roll < 66) kind = KIND_RESET;
         else if (roll < 76) kind = KIND_UNKNOWN;
         else if (roll < 88) kind = KIND_BAD_HEADER;
         else                kind = KIND_NOISE;
      end
      second = HDR_SECOND;
      op = 8'($urandom_range(255));
      case (kind)
         KIND_ADD:    op = OP_ADD;
         KIND_DELETE: op = OP_DELETE;
         KIND_DUMP:   op = OP_DUMP;
         KIND_SCAN:   op = OP_SCAN;
         KIND_RESET:  op = OP_RESET;
         KIND_UNKNOWN: begin
            if (op >= OP_ADD && op <= OP_RESET) op = op ^ 8'h40;
         end
         KIND_BAD_HEADER: begin
            second = 8'($urandom_range(255));
            if (second == HDR_SECOND) second = ~second;
         end
         default: ;
      endcase
      if (kind == KIND_NOISE) begin
         // a stray byte that cannot start a frame
         if (op == HDR_FIRST) op = ~op;
         pending_bytes.push_back(op);
      end else begin
         queue_frame(op, second, mac_pool[$urandom_range(MAC_POOL - 1)]);
      end
   endtask

   task automatic queue_random(input int budget, input int add_pct);
      int start;
      start = frame_bytes_queued;
      while (frame_bytes_queued - start < budget) queue_random_frame(add_pct);
   endtask

   initial begin
      frame_len_cfg = FRAME_LEN_RESET;
      gather_idx = '0;
      mac_count = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) mac_table[i] = '0;
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      for (int i = 2; i < MAC_POOL; i++) mac_pool[i] = {16'($urandom), $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset frame length, no idling
      queue_random(20, 60);
      wait_drained();

      // directed frames at a length below the minimum, from an emptied table
      write_frame_length(7'd5);
      for (int i = 0; i < mac_count; i++) queue_frame(OP_DELETE, HDR_SECOND, mac_table[i]);
      queue_frame(OP_DUMP, HDR_SECOND, '0);         // empty table: count byte only
      queue_frame(OP_ADD, HDR_SECOND, '0);
      queue_frame(OP_ADD, HDR_SECOND, '1);
      queue_frame(OP_ADD, HDR_SECOND, '1);          // already present
      queue_frame(OP_DUMP, HDR_SECOND, '0);
      queue_frame(OP_DELETE, HDR_SECOND, '0);       // later entry moves down
      queue_frame(OP_DELETE, HDR_SECOND, 48'h0123_4567_89ab);
      queue_frame(OP_SCAN, HDR_SECOND, '0);
      queue_frame(OP_RESET, HDR_SECOND, '1);
      queue_frame(8'h00, HDR_SECOND, '0);
      queue_frame(8'hff, HDR_SECOND, '1);
      queue_frame(OP_ADD, 8'h00, '0);               // bad second header byte
      queue_frame(OP_ADD, 8'hff, '1);
      pending_bytes.push_back(8'h00);               // dropped first bytes
      pending_bytes.push_back(8'hff);
      queue_frame(OP_DUMP, HDR_SECOND, '0);
      wait_drained();

      // shortest frames, add-heavy, sender mostly idle
      write_frame_length(FRAME_LEN_MIN);
      send_idle_pct = 84;
      queue_random(30, 70);
      wait_drained();

      // longest frames, light idling on both sides
      write_frame_length(7'd64);
      send_idle_pct = 11;
      stall_pct = 11;
      queue_random(64, 40);
      wait_drained();

      write_frame_length(7'($urandom_range(24, 11)));
      send_idle_pct = 0;
      stall_pct = 84;
      queue_random(30, 35);
      wait_drained();

      // receiver holds off while bytes keep coming, then the sender pauses
      write_frame_length(FRAME_LEN_MIN);
      stall_pct = 0;
      hold_token++;
      repeat (3) queue_frame(OP_SCAN, HDR_SECOND, '0);
      wait_drained();
      queue_random(20, 40);
      wait_drained();

      write_frame_length(7'($urandom_range(16, 10)));
      send_idle_pct = 11;
      stall_pct = 11;
      random_start = frame_bytes_queued;
      while (frame_bytes_queued - random_start < 20 || replies_checked < 60) begin
         queue_random_frame(40);
         while (pending_bytes.size() > 32) @(posedge clock);
      end
      wait_drained();

      if (expected_replies.size() != 0) begin
         $display("%0t: %0d expected replies never arrived", $time, expected_replies.size());
         mismatch_count++;
      end
      $display("covered %0d bytes over frame lengths 5 to 64, %0d reply bytes checked",
               bytes_accepted, replies_checked);
      $display("%0d dumps, table peak %0d of %0d entries, %0d adds refused on a full table",
               dump_count, peak_entries, TABLE_ENTRIES, add_refusals);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d replies outstanding", $time, expected_replies.size());
      $display("Verification failed");
      $finish;
   end

endmodule
